// ===== src/remote_stop_command_decoder_defines.svh =====
// Assertion macros shared by the remote stop command decoder modules
`ifndef REMOTE_STOP_COMMAND_DECODER_DEFINES_SVH
`define REMOTE_STOP_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset
`define RSCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rscd check failed");

// Next-cycle implication, checked on clk outside reset
`define RSCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rscd check failed");

`endif

// ===== src/rscd_pkg.sv =====
// Shared types, codes and constants of the remote stop command decoder
package rscd_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int LINE_DEPTH   = BUFFER_BYTES - 1;
    localparam int COUNT_W      = $clog2(LINE_DEPTH);

    localparam int TIMEOUT_W = 17;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = {TIMEOUT_W{1'b1}};

    // Operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Event codes
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_STOP    = 4'd1;
    localparam logic [3:0] EV_START   = 4'd2;
    localparam logic [3:0] EV_REFUSED = 4'd3;
    localparam logic [3:0] EV_EMERG   = 4'd4;
    localparam logic [3:0] EV_UNKNOWN = 4'd5;
    localparam logic [3:0] EV_OVERFL  = 4'd6;
    localparam logic [3:0] EV_RESUME  = 4'd7;
    localparam logic [3:0] EV_CLEARED = 4'd8;

    // Acknowledge codes
    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_STOP  = 2'd1;
    localparam logic [1:0] ACK_START = 2'd2;

    // Command words, first character in the top byte
    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam int STOP_LEN  = 4;
    localparam int START_LEN = 5;
    localparam int EMERG_LEN = 9;
    localparam logic [8*STOP_LEN-1:0]  WORD_STOP  = "STOP";
    localparam logic [8*START_LEN-1:0] WORD_START = "START";
    localparam logic [8*EMERG_LEN-1:0] WORD_EMERG = "EMERGENCY";

    // Line unit status for the item in process
    typedef struct packed {
        logic done;
        logic overflow;
        logic stop_match;
        logic start_match;
        logic emerg_match;
    } line_status_t;

    // One result item
    typedef struct packed {
        logic       stopped;
        logic       emergency;
        logic [3:0] event_res;
        logic [1:0] ack_code;
    } result_t;

endpackage

// ===== src/rscd_line_buf.sv =====
// Line buffer, fill count and command word matching
module rscd_line_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  is_byte,
    input  logic [7:0]            rx_byte,
    output rscd_pkg::line_status_t status
);
    import rscd_pkg::*;

    `include "remote_stop_command_decoder_defines.svh"

    logic [7:0]         line_mem [LINE_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               full;
    logic               newline;

    // Flag a full line and a line end
    assign full    = (count_reg == COUNT_W'(LINE_DEPTH - 1));
    assign newline = (rx_byte == NEWLINE);

    // Match the stored characters; the newline itself sits at count_reg
    always_comb
    begin
        status.overflow    = is_byte && full;
        status.done        = is_byte && !full && newline;
        status.stop_match  = (count_reg == COUNT_W'(STOP_LEN)) &&
            ({line_mem[0], line_mem[1], line_mem[2], line_mem[3]} == WORD_STOP);
        status.start_match = (count_reg == COUNT_W'(START_LEN)) &&
            ({line_mem[0], line_mem[1], line_mem[2], line_mem[3],
              line_mem[4]} == WORD_START);
        status.emerg_match = (count_reg == COUNT_W'(EMERG_LEN)) &&
            ({line_mem[0], line_mem[1], line_mem[2], line_mem[3], line_mem[4],
              line_mem[5], line_mem[6], line_mem[7], line_mem[8]} == WORD_EMERG);
    end

    // Advance the count, drop the line on overflow or line end
    always_comb
    begin
        count_next = count_reg;
        if (fire && is_byte)
        begin
            if (full || newline)
                count_next = '0;
            else
                count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Store each received byte at the fill position
    always_ff @(posedge clk)
    begin
        if (fire && is_byte)
            line_mem[count_reg] <= rx_byte;
    end

    `RSCD_ASSERT_IMP(a_count_range, 1'b1, count_reg <= COUNT_W'(LINE_DEPTH - 1))
    `RSCD_ASSERT_NXT(a_overflow_drop, fire && status.overflow, count_reg == '0)
    `RSCD_ASSERT_NXT(a_line_end_drop, fire && status.done, count_reg == '0)

endmodule

// ===== src/rscd_ctrl.sv =====
// Stop and emergency flags, idle counter and result encoding
module rscd_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  logic [1:0]                         operation,
    input  rscd_pkg::line_status_t             status,
    input  logic [rscd_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    output rscd_pkg::result_t                  result
);
    import rscd_pkg::*;

    `include "remote_stop_command_decoder_defines.svh"

    logic                 stop_reg;
    logic                 stop_next;
    logic                 emerg_reg;
    logic                 emerg_next;
    logic [TIMEOUT_W-1:0] idle_reg;
    logic [TIMEOUT_W-1:0] idle_next;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic [3:0]           event_code;
    logic [1:0]           ack;

    // Saturating tick count
    assign idle_inc = (idle_reg < IDLE_MAX) ? idle_reg + TIMEOUT_W'(1) : idle_reg;

    // Decode the item against the current flags
    always_comb
    begin
        stop_next  = stop_reg;
        emerg_next = emerg_reg;
        idle_next  = idle_reg;
        event_code = EV_NONE;
        ack        = ACK_NONE;
        case (operation)
            OP_BYTE:
            begin
                if (status.overflow)
                    event_code = EV_OVERFL;
                else if (status.done)
                begin
                    idle_next = '0;
                    if (status.stop_match)
                    begin
                        stop_next  = 1'b1;
                        event_code = EV_STOP;
                        ack        = ACK_STOP;
                    end
                    else if (status.start_match)
                    begin
                        if (!emerg_reg)
                        begin
                            stop_next  = 1'b0;
                            event_code = EV_START;
                            ack        = ACK_START;
                        end
                        else
                            event_code = EV_REFUSED;
                    end
                    else if (status.emerg_match)
                    begin
                        stop_next  = 1'b1;
                        emerg_next = 1'b1;
                        event_code = EV_EMERG;
                        ack        = ACK_STOP;
                    end
                    else
                        event_code = EV_UNKNOWN;
                end
            end
            OP_TICK:
            begin
                idle_next = idle_inc;
                if (stop_reg && !emerg_reg && (idle_inc > timeout_ticks))
                begin
                    stop_next  = 1'b0;
                    event_code = EV_RESUME;
                    ack        = ACK_START;
                end
            end
            OP_CLEAR:
            begin
                stop_next  = 1'b0;
                emerg_next = 1'b0;
                event_code = EV_CLEARED;
            end
            default:
            begin
                event_code = EV_NONE;
            end
        endcase
    end

    assign result.stopped   = stop_next;
    assign result.emergency = emerg_next;
    assign result.event_res = event_code;
    assign result.ack_code  = ack;

    // Hold the flags and idle count, update on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg  <= 1'b0;
            emerg_reg <= 1'b0;
            idle_reg  <= '0;
        end
        else if (fire)
        begin
            stop_reg  <= stop_next;
            emerg_reg <= emerg_next;
            idle_reg  <= idle_next;
        end
    end

    `RSCD_ASSERT_IMP(a_emerg_implies_stop, emerg_reg, stop_reg)
    `RSCD_ASSERT_NXT(a_line_end_restarts_idle,
        fire && (operation == OP_BYTE) && status.done, idle_reg == '0)
    `RSCD_ASSERT_NXT(a_clear_drops_flags,
        fire && (operation == OP_CLEAR), !stop_reg && !emerg_reg)

endmodule

// ===== src/remote_stop_command_decoder.sv =====
// Remote stop command decoder: top level with input and result registers
//
// Input channel (in_valid/in_ready) carries one transaction per item:
// operation 0 is a received byte in rx_byte, 1 a millisecond tick, 2 a
// manual emergency clear; code 3 is ignored and still gives a result.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// the stop flag, the emergency latch, an event code and an ack code.
// An accepted item is decoded while it sits in the input register, and
// its result is captured in the result register and shown from there.
// Throughput is one item per cycle: the input register, the decode logic
// and the result register advance together whenever the result register
// is empty or being taken. When the receiver stalls, the result is held
// and one more item waits in the input register before in_ready drops.
// cfg_wr_en writes timeout_ticks from cfg_wr_data at once.
// Reset clears the line count, both flags, the idle counter and all valid
// bits, and sets timeout_ticks to 10000; the line storage is not cleared.
module remote_stop_command_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               stopped,
    output logic                               emergency,
    output logic [3:0]                         event_res,
    output logic [1:0]                         ack_code,
    input  logic                               cfg_wr_en,
    input  logic [rscd_pkg::TIMEOUT_W-1:0]     cfg_wr_data
);
    import rscd_pkg::*;

    `include "remote_stop_command_decoder_defines.svh"

    logic                 s1_valid_reg;
    logic [1:0]           op_reg;
    logic [7:0]           byte_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 advance;
    logic                 fire;
    line_status_t         status;

    // Advance when the result register is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_wr_en)
            timeout_reg <= cfg_wr_data;
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= operation;
            byte_reg <= rx_byte;
        end
    end

    rscd_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .is_byte (op_reg == OP_BYTE),
        .rx_byte (byte_reg),
        .status  (status)
    );

    rscd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .operation     (op_reg),
        .status        (status),
        .timeout_ticks (timeout_reg),
        .result        (result_next)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign stopped   = result_reg.stopped;
    assign emergency = result_reg.emergency;
    assign event_res = result_reg.event_res;
    assign ack_code  = result_reg.ack_code;

    `RSCD_ASSERT_IMP(a_out_emerg_stopped, out_valid_reg && result_reg.emergency,
        result_reg.stopped)
    `RSCD_ASSERT_IMP(a_out_ack_stop, out_valid_reg && (result_reg.ack_code == ACK_STOP),
        (result_reg.event_res == EV_STOP) || (result_reg.event_res == EV_EMERG))
    `RSCD_ASSERT_NXT(a_stall_keeps_input, s1_valid_reg && !advance, s1_valid_reg)

endmodule
